// ===== design/cmflt_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN mask filter table package
// Sizes, operation codes, field layouts and address helpers shared by the
// mask filter table and its checker.
// ----------------------------------------------------------------------------
package cmflt_pkg;

   localparam int NUM_BUSES   = 2;
   localparam int NUM_OBJECTS = 16;
   localparam int MAX_ENTRIES = 16;

   localparam int SLOT_COUNT  = NUM_BUSES * NUM_OBJECTS;
   localparam int ENTRY_TOTAL = SLOT_COUNT * MAX_ENTRIES;
   localparam int SLOT_AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ENTRY_AW    = (ENTRY_TOTAL > 1) ? $clog2(ENTRY_TOTAL) : 1;

   localparam int ID_W    = 29;
   localparam int BOX_W   = 10;
   localparam int OBJ_W   = 8;
   localparam int EIDX_W  = 4;
   localparam int CNT_W   = 5;
   localparam int OP_W    = 2;
   localparam int NUM_CSR = 2;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_WRITE_ENTRY = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_COUNT   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_BUS   = 2'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OBJECT_BUS0 = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OBJECT_BUS1 = 1'd1;

   // request tdata layout
   localparam int REQ_TDATA_W = 120;
   localparam int REQ_TUSER_W = 3;

   // response tdata layout
   localparam int RSP_TDATA_W     = 16;
   localparam int RSP_STATUS_BIT  = 0;
   localparam int RSP_FOUND_BIT   = 1;
   localparam int RSP_BOX_LSB     = 2;
   localparam int RSP_PRESENT_BIT = 12;

   typedef logic [SLOT_AW-1:0]  slot_addr_type;
   typedef logic [ENTRY_AW-1:0] entry_addr_type;
   typedef logic [CSR_W-1:0]    min_object_type [NUM_CSR];

   typedef struct packed {
      logic [BOX_W-1:0] box;
      logic [ID_W-1:0]  filter;
      logic [ID_W-1:0]  mask;
   } entry_type;

   typedef struct packed {
      logic             present;
      logic [BOX_W-1:0] box;
      logic             found;
      logic             status;
   } result_type;

   function automatic slot_addr_type slot_addr(input logic bus, input logic [OBJ_W-1:0] obj);
      int unsigned s;
      s = 32'(bus) * NUM_OBJECTS + 32'(obj);
      return SLOT_AW'(s);
   endfunction

   function automatic entry_addr_type entry_addr(input slot_addr_type slot,
                                                 input logic [CNT_W-1:0] idx);
      int unsigned a;
      a = 32'(slot) * MAX_ENTRIES + 32'(idx);
      return ENTRY_AW'(a);
   endfunction

endpackage

// ===== design/cmflt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cmflt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cmflt_engine.sv =====
// ----------------------------------------------------------------------------
// Mask filter table engine
// Decodes one operation, updates the entry and count memories and scans a
// slot's entries from the highest index down for a lookup.
// ----------------------------------------------------------------------------
module cmflt_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  logic [cmflt_pkg::OP_W-1:0]     operation,
   input  logic                           bus,
   input  logic [cmflt_pkg::OBJ_W-1:0]    object,
   input  logic [cmflt_pkg::EIDX_W-1:0]   entry_index,
   input  logic [cmflt_pkg::ID_W-1:0]     mask,
   input  logic [cmflt_pkg::ID_W-1:0]     filter,
   input  logic [cmflt_pkg::BOX_W-1:0]    box_index,
   input  logic [cmflt_pkg::CNT_W-1:0]    entry_count,
   input  logic [cmflt_pkg::ID_W-1:0]     message_id,
   input  cmflt_pkg::min_object_type      min_object,
   output logic                           res_valid,
   input  logic                           res_ready,
   output cmflt_pkg::result_type          res
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   cmflt_pkg::slot_addr_type        slot_ff, slot_in;
   logic [cmflt_pkg::ID_W-1:0]      mid_ff, mid_in;
   logic [cmflt_pkg::CNT_W-1:0]     scan_ff, scan_in;
   cmflt_pkg::result_type           res_ff, res_in;
   logic [cmflt_pkg::SLOT_COUNT-1:0] valid_ff, valid_in;

   logic                            accept;
   logic                            bus_ok, obj_ok, idx_ok, lk_ok;
   logic [cmflt_pkg::OBJ_W-1:0]     base, diff;
   cmflt_pkg::slot_addr_type        wr_slot, lk_slot;
   logic [cmflt_pkg::CNT_W-1:0]     sat_count, cur_count;

   logic                            cnt_wr_en, cnt_rd_en;
   logic [cmflt_pkg::CNT_W-1:0]     cnt_rd_data;
   logic                            ent_wr_en, ent_rd_en;
   cmflt_pkg::entry_addr_type       ent_wr_addr, ent_rd_addr;
   cmflt_pkg::entry_type            ent_wr_data, ent_rd_data;
   logic [cmflt_pkg::CNT_W-1:0]     rd_idx;
   logic                            hit;

   assign item_ready = (state_ff == ST_IDLE);
   assign accept     = item_valid && item_ready;
   assign res_valid  = (state_ff == ST_DONE);
   assign res        = res_ff;

   assign bus_ok  = 32'(bus) < cmflt_pkg::NUM_BUSES;
   assign obj_ok  = 32'(object) < cmflt_pkg::NUM_OBJECTS;
   assign idx_ok  = 32'(entry_index) < cmflt_pkg::MAX_ENTRIES;
   assign base    = min_object[bus];
   assign diff    = object - base;
   assign lk_ok   = (object >= base) && (32'(diff) < cmflt_pkg::NUM_OBJECTS);
   assign wr_slot = cmflt_pkg::slot_addr(bus, object);
   assign lk_slot = cmflt_pkg::slot_addr(bus, diff);
   assign sat_count = (32'(entry_count) > cmflt_pkg::MAX_ENTRIES) ?
                      cmflt_pkg::CNT_W'(cmflt_pkg::MAX_ENTRIES) : entry_count;

   assign cnt_wr_en = accept && (operation == cmflt_pkg::OP_SET_COUNT) && bus_ok && obj_ok;
   assign cnt_rd_en = accept && (operation == cmflt_pkg::OP_LOOKUP) && bus_ok && lk_ok;

   assign ent_wr_en   = accept && (operation == cmflt_pkg::OP_WRITE_ENTRY) && bus_ok &&
                        obj_ok && idx_ok;
   assign ent_wr_addr = cmflt_pkg::entry_addr(wr_slot, cmflt_pkg::CNT_W'(entry_index));
   assign ent_wr_data = '{box: box_index, filter: filter, mask: mask};

   assign cur_count = valid_ff[slot_ff] ? cnt_rd_data : '0;
   assign hit       = ((ent_rd_data.mask & mid_ff) == ent_rd_data.filter);
   assign rd_idx    = (state_ff == ST_COUNT) ? (cur_count - 1'b1) : (scan_ff - 1'b1);
   assign ent_rd_addr = cmflt_pkg::entry_addr(slot_ff, rd_idx);
   assign ent_rd_en = ((state_ff == ST_COUNT) && (cur_count != '0)) ||
                      ((state_ff == ST_SCAN) && !hit && (scan_ff != '0));

   cmflt_ram #(
      .WIDTH (cmflt_pkg::CNT_W),
      .DEPTH (cmflt_pkg::SLOT_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (wr_slot),
      .wr_data (sat_count),
      .rd_en   (cnt_rd_en),
      .rd_addr (lk_slot),
      .rd_data (cnt_rd_data)
   );

   cmflt_ram #(
      .WIDTH ($bits(cmflt_pkg::entry_type)),
      .DEPTH (cmflt_pkg::ENTRY_TOTAL)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      mid_in   = mid_ff;
      scan_in  = scan_ff;
      res_in   = res_ff;
      valid_in = valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               slot_in  = lk_slot;
               mid_in   = message_id;
               state_in = ST_DONE;
               if (!bus_ok) begin
                  res_in.status = 1'b1;
               end else begin
                  unique case (operation)
                     cmflt_pkg::OP_WRITE_ENTRY: begin
                        res_in.status = !(obj_ok && idx_ok);
                     end
                     cmflt_pkg::OP_SET_COUNT: begin
                        res_in.status = !obj_ok;
                        if (obj_ok) begin
                           valid_in[wr_slot] = 1'b1;
                        end
                     end
                     cmflt_pkg::OP_CLEAR_BUS: begin
                        for (int s = 0; s < cmflt_pkg::SLOT_COUNT; s++) begin
                           if ((s >= int'(bus) * cmflt_pkg::NUM_OBJECTS) &&
                               (s < (int'(bus) + 1) * cmflt_pkg::NUM_OBJECTS)) begin
                              valid_in[s] = 1'b0;
                           end
                        end
                     end
                     cmflt_pkg::OP_LOOKUP: begin
                        res_in.status = !lk_ok;
                        if (lk_ok) begin
                           state_in = ST_COUNT;
                        end
                     end
                     default: begin
                        res_in.status = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_COUNT: begin
            res_in.present = (cur_count != '0);
            scan_in        = rd_idx;
            state_in       = (cur_count != '0) ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            priority if (hit) begin
               res_in.found = 1'b1;
               res_in.box   = ent_rd_data.box;
               state_in     = ST_DONE;
            end else if (scan_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               scan_in = rd_idx;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      slot_ff <= slot_in;
      mid_ff  <= mid_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
   end

endmodule

// ===== design/can_mask_filter_lookup_table_top.sv =====
// ----------------------------------------------------------------------------
// CAN mask filter lookup table
// Per bus and message-object tables of mask, filter and box entries with
// entry counts; write, count, clear and identifier lookup operations.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   req_tuser, req_tdata
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata
//   csr      in         csr_valid/csr_ready     csr_index, csr_wdata
//
// Write entry, set count and clear bus go from the idle state straight to the
// result state. A lookup reads the slot's count, then scans its entries from the
// highest index down; the entry memory delivers one entry a cycle to the match compare.
// One item is in work at a time; the next is taken while a result waits in
// the output register. Reset clears all counts at once through per-slot
// valid flags; entry memories keep their contents.
// ----------------------------------------------------------------------------
module can_mask_filter_lookup_table_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] operation, [2] bus
   input  logic [cmflt_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // [7:0] object, [11:8] entry_index, [40:12] mask, [69:41] filter,
   // [79:70] box_index, [84:80] entry_count, [113:85] message_id
   input  logic [cmflt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] status, [1] found, [11:2] box_index_found, [12] table_present
   output logic [cmflt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cmflt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cmflt_pkg::CSR_W-1:0]          csr_wdata
);
   cmflt_pkg::min_object_type       min_object_ff;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   cmflt_pkg::result_type           rsp_res_ff;
   logic                            res_valid, res_ready;
   cmflt_pkg::result_type           res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_object_ff[0] <= '0;
         min_object_ff[1] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cmflt_pkg::CSR_MIN_OBJECT_BUS0: min_object_ff[0] <= csr_wdata;
            cmflt_pkg::CSR_MIN_OBJECT_BUS1: min_object_ff[1] <= csr_wdata;
            default: ;
         endcase
      end
   end

   cmflt_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .operation   (req_tuser[1:0]),
      .bus         (req_tuser[2]),
      .object      (req_tdata[7:0]),
      .entry_index (req_tdata[11:8]),
      .mask        (req_tdata[40:12]),
      .filter      (req_tdata[69:41]),
      .box_index   (req_tdata[79:70]),
      .entry_count (req_tdata[84:80]),
      .message_id  (req_tdata[113:85]),
      .min_object  (min_object_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // hold the result until transfer; refill in the same cycle it drains
   assign res_ready     = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid_in = (res_valid && res_ready) || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (res_valid && res_ready) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff};

endmodule

// ===== design/cmflt_checker.sv =====
// ----------------------------------------------------------------------------
// Mask filter table checker
// Port-level checks on response consistency and request flow.
// ----------------------------------------------------------------------------
module cmflt_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [cmflt_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   logic       status, found, present;
   logic [9:0] box;

   assign status  = rsp_tdata[cmflt_pkg::RSP_STATUS_BIT];
   assign found   = rsp_tdata[cmflt_pkg::RSP_FOUND_BIT];
   assign present = rsp_tdata[cmflt_pkg::RSP_PRESENT_BIT];
   assign box     = rsp_tdata[cmflt_pkg::RSP_BOX_LSB +: cmflt_pkg::BOX_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status |-> !found && !present && (box == '0))
      else $error("rejected item reports lookup fields");

   a_miss_box: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !found |-> (box == '0))
      else $error("box index without a match");

   a_found_present: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found |-> present)
      else $error("match in an empty table");

endmodule

bind can_mask_filter_lookup_table_top cmflt_checker u_cmflt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/can_mask_filter_lookup_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// CAN mask filter lookup table testbench
// Drives write entry, set count, clear bus and lookup requests into the table
// through the request stream, sets the per-bus lowest object numbers between
// phases, and checks every response against a cycle-free model of the tables
// kept in a scoreboard. Both stream sides idle at random; one stretch runs
// without idling.
// ----------------------------------------------------------------------------
typedef struct packed {
   logic [cmflt_pkg::OP_W-1:0]   op;
   logic                         bus;
   logic [cmflt_pkg::OBJ_W-1:0]  obj;
   logic [cmflt_pkg::EIDX_W-1:0] eidx;
   logic [cmflt_pkg::ID_W-1:0]   mask;
   logic [cmflt_pkg::ID_W-1:0]   filter;
   logic [cmflt_pkg::BOX_W-1:0]  box;
   logic [cmflt_pkg::CNT_W-1:0]  cnt;
   logic [cmflt_pkg::ID_W-1:0]   mid;
} table_op_type;

class filter_table_model;
   logic [cmflt_pkg::ID_W-1:0]  mask_mem   [cmflt_pkg::ENTRY_TOTAL];
   logic [cmflt_pkg::ID_W-1:0]  filter_mem [cmflt_pkg::ENTRY_TOTAL];
   logic [cmflt_pkg::BOX_W-1:0] box_mem    [cmflt_pkg::ENTRY_TOTAL];
   bit                          written    [cmflt_pkg::ENTRY_TOTAL];
   logic [cmflt_pkg::CNT_W-1:0] count_mem  [cmflt_pkg::SLOT_COUNT];
   logic [cmflt_pkg::CSR_W-1:0] min_obj    [cmflt_pkg::NUM_CSR];
   cmflt_pkg::result_type       expected_results [$];
   int unsigned                 errors;

   function new();
      foreach (count_mem[s]) count_mem[s] = '0;
      foreach (written[a]) written[a] = 1'b0;
      foreach (min_obj[i]) min_obj[i] = '0;
      errors = 0;
   endfunction

   function void set_min(logic [cmflt_pkg::CSR_IDX_W-1:0] idx,
                         logic [cmflt_pkg::CSR_W-1:0] value);
      min_obj[idx] = value;
   endfunction

   function cmflt_pkg::result_type predict_result(table_op_type t);
      cmflt_pkg::result_type r;
      int unsigned slot;
      int unsigned a;
      int unsigned diff;
      int          e;
      r = '0;
      case (t.op)
         cmflt_pkg::OP_WRITE_ENTRY: begin
            if (t.obj >= cmflt_pkg::NUM_OBJECTS || t.eidx >= cmflt_pkg::MAX_ENTRIES) begin
               r.status = 1'b1;
            end else begin
               a = (t.bus * cmflt_pkg::NUM_OBJECTS + t.obj) * cmflt_pkg::MAX_ENTRIES +
                   t.eidx;
               mask_mem[a]   = t.mask;
               filter_mem[a] = t.filter;
               box_mem[a]    = t.box;
               written[a]    = 1'b1;
            end
         end
         cmflt_pkg::OP_SET_COUNT: begin
            if (t.obj >= cmflt_pkg::NUM_OBJECTS) begin
               r.status = 1'b1;
            end else begin
               slot = t.bus * cmflt_pkg::NUM_OBJECTS + t.obj;
               count_mem[slot] = (t.cnt > cmflt_pkg::MAX_ENTRIES) ?
                                 cmflt_pkg::CNT_W'(cmflt_pkg::MAX_ENTRIES) : t.cnt;
            end
         end
         cmflt_pkg::OP_CLEAR_BUS: begin
            for (int s = 0; s < cmflt_pkg::NUM_OBJECTS; s++) begin
               count_mem[t.bus * cmflt_pkg::NUM_OBJECTS + s] = '0;
            end
         end
         default: begin
            if (t.obj < min_obj[t.bus]) begin
               r.status = 1'b1;
            end else begin
               diff = t.obj - min_obj[t.bus];
               if (diff >= cmflt_pkg::NUM_OBJECTS) begin
                  r.status = 1'b1;
               end else begin
                  slot = t.bus * cmflt_pkg::NUM_OBJECTS + diff;
                  r.present = (count_mem[slot] != 0);
                  for (e = int'(count_mem[slot]) - 1; e >= 0 && !r.found; e--) begin
                     a = slot * cmflt_pkg::MAX_ENTRIES + e;
                     if ((mask_mem[a] & t.mid) == filter_mem[a]) begin
                        r.found = 1'b1;
                        r.box   = box_mem[a];
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   function void note_request(table_op_type t);
      expected_results.push_back(predict_result(t));
   endfunction

   task report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got 'h%0h, want 'h%0h", $time, what, got, want);
      errors++;
   endtask

   task check_response(logic [cmflt_pkg::RSP_TDATA_W-1:0] data);
      cmflt_pkg::result_type got;
      cmflt_pkg::result_type want;
      got = cmflt_pkg::result_type'(data[$bits(cmflt_pkg::result_type)-1:0]);
      if (expected_results.size() == 0) begin
         report("unexpected response", data, 0);
         return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.found !== want.found) report("found", got.found, want.found);
      if (got.box !== want.box) report("box_index_found", got.box, want.box);
      if (got.present !== want.present) report("table_present", got.present, want.present);
   endtask
endclass

module can_mask_filter_lookup_table_top_tb;

   localparam int STALL_LIMIT = 3000;
   localparam int PHASE_ITEMS = 320;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [cmflt_pkg::REQ_TUSER_W-1:0] req_tuser;
   logic [cmflt_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [cmflt_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [cmflt_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [cmflt_pkg::CSR_W-1:0]       csr_wdata;

   filter_table_model filter_tables;
   bit                quiet;
   int unsigned       stall_cycles;

   can_mask_filter_lookup_table_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) rsp_tready <= quiet || ($urandom_range(99) >= 20);

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) filter_tables.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic table_op_type table_op(logic [cmflt_pkg::OP_W-1:0] op, logic bus,
                                             logic [cmflt_pkg::OBJ_W-1:0] obj,
                                             logic [cmflt_pkg::EIDX_W-1:0] eidx,
                                             logic [cmflt_pkg::ID_W-1:0] mask,
                                             logic [cmflt_pkg::ID_W-1:0] filter,
                                             logic [cmflt_pkg::BOX_W-1:0] box,
                                             logic [cmflt_pkg::CNT_W-1:0] cnt,
                                             logic [cmflt_pkg::ID_W-1:0] mid);
      table_op_type t;
      t = '{op, bus, obj, eidx, mask, filter, box, cnt, mid};
      return t;
   endfunction

   function automatic table_op_type make_random_item();
      table_op_type t;
      int unsigned  pick;
      int unsigned  base;
      int unsigned  slot;
      int unsigned  n;
      int unsigned  k;
      int unsigned  a;
      t.op     = cmflt_pkg::OP_LOOKUP;
      t.bus    = 1'($urandom);
      t.obj    = cmflt_pkg::OBJ_W'($urandom);
      t.eidx   = cmflt_pkg::EIDX_W'($urandom);
      t.mask   = cmflt_pkg::ID_W'($urandom);
      t.filter = cmflt_pkg::ID_W'($urandom);
      t.box    = cmflt_pkg::BOX_W'($urandom);
      t.cnt    = cmflt_pkg::CNT_W'($urandom);
      t.mid    = cmflt_pkg::ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
         t.op = cmflt_pkg::OP_WRITE_ENTRY;
         if ($urandom_range(9) != 0) begin
            t.obj = cmflt_pkg::OBJ_W'($urandom_range(cmflt_pkg::NUM_OBJECTS - 1));
         end
         case ($urandom_range(3))
            0: t.mask = '1;
            1: t.mask = cmflt_pkg::ID_W'($urandom_range(2047));
            2: t.mask = '0;
            default: ;
         endcase
         if ($urandom_range(4) != 0) t.filter = t.mask & cmflt_pkg::ID_W'($urandom);
      end else if (pick < 50) begin
         t.op = cmflt_pkg::OP_SET_COUNT;
         if ($urandom_range(9) != 0) begin
            t.obj = cmflt_pkg::OBJ_W'($urandom_range(cmflt_pkg::NUM_OBJECTS - 1));
         end
         case ($urandom_range(6))
            0: t.cnt = '0;
            1: t.cnt = cmflt_pkg::CNT_W'($urandom_range(31, cmflt_pkg::MAX_ENTRIES + 1));
            default: t.cnt = cmflt_pkg::CNT_W'($urandom_range(cmflt_pkg::MAX_ENTRIES, 1));
         endcase
      end else if (pick < 54) begin
         t.op = cmflt_pkg::OP_CLEAR_BUS;
      end else begin
         base = filter_tables.min_obj[t.bus];
         if ($urandom_range(6) != 0) begin
            k = base + $urandom_range(cmflt_pkg::NUM_OBJECTS - 1);
            t.obj = (k > 255) ? 8'd255 : cmflt_pkg::OBJ_W'(k);
         end
         if ($urandom_range(1) != 0) t.mid = cmflt_pkg::ID_W'($urandom_range(2047));
         if (t.obj >= base && t.obj - base < cmflt_pkg::NUM_OBJECTS) begin
            slot = t.bus * cmflt_pkg::NUM_OBJECTS + (t.obj - base);
            n = filter_tables.count_mem[slot];
            k = n;
            for (int e = n; e > 0; e--) begin
               if (!filter_tables.written[slot * cmflt_pkg::MAX_ENTRIES + e - 1]) k = e - 1;
            end
            if (k < n) begin
               // fill the slot before it may be scanned
               t.op     = cmflt_pkg::OP_WRITE_ENTRY;
               t.obj    = cmflt_pkg::OBJ_W'(t.obj - base);
               t.eidx   = cmflt_pkg::EIDX_W'(k);
               t.filter = t.mask & cmflt_pkg::ID_W'($urandom);
            end else if (n != 0 && $urandom_range(9) < 7) begin
               a = slot * cmflt_pkg::MAX_ENTRIES + $urandom_range(n - 1);
               t.mid = filter_tables.filter_mem[a] | (~filter_tables.mask_mem[a] & t.mid);
            end
         end
      end
      return t;
   endfunction

   task automatic send_request(table_op_type t);
      req_tuser  <= {t.bus, t.op};
      req_tdata  <= cmflt_pkg::REQ_TDATA_W'({t.mid, t.cnt, t.box, t.filter, t.mask,
                                              t.eidx, t.obj});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      filter_tables.note_request(t);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (filter_tables.expected_results.size() != 0);
   endtask

   task automatic write_min_object(logic [cmflt_pkg::CSR_IDX_W-1:0] idx,
                                   logic [cmflt_pkg::CSR_W-1:0] value);
      wait_drained();
      repeat (25) @(negedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      filter_tables.set_min(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      filter_tables = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      quiet      = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS0, 8'd0);
      write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS1, 8'd4);

      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 0, 0, 0, '0, '0, 10'h005, 0, '0));
      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 0, 0, 1, '1, '1, 10'h3FF, 0, '0));
      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 0, 0, 2, 29'h7FF, 29'h123, 10'h2AA,
                            0, '0));
      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 0, 16, 0, '1, '0, 10'h001, 0, '0));
      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 1, 255, 15, '1, '0, 10'h001, 0, '0));
      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 1, 15, 15, '1, '0, 10'h001, 0, '0));
      send_request(table_op(cmflt_pkg::OP_SET_COUNT, 0, 0, 0, '0, '0, '0, 5'd3, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 0, 0, 0, '0, '0, '0, 0, 29'h123));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 0, 0, 0, '0, '0, '0, 0, '1));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 0, 0, 0, '0, '0, '0, 0, '0));
      send_request(table_op(cmflt_pkg::OP_SET_COUNT, 0, 1, 0, '0, '0, '0, 5'd0, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 0, 1, 0, '0, '0, '0, 0, 29'h5A5));
      send_request(table_op(cmflt_pkg::OP_SET_COUNT, 1, 200, 0, '0, '0, '0, 5'd4, '0));
      send_request(table_op(cmflt_pkg::OP_SET_COUNT, 1, 3, 0, '0, '0, '0, 5'd31, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 0, 16, 0, '0, '0, '0, 0, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 1, 2, 0, '0, '0, '0, 0, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 1, 255, 0, '0, '0, '0, 0, '0));
      send_request(table_op(cmflt_pkg::OP_WRITE_ENTRY, 1, 0, 0, '1, 29'h1555, 10'h3FF,
                            0, '0));
      send_request(table_op(cmflt_pkg::OP_SET_COUNT, 1, 0, 0, '0, '0, '0, 5'd1, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 1, 4, 0, '0, '0, '0, 0, 29'h1555));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 1, 4, 0, '0, '0, '0, 0, 29'h1556));
      send_request(table_op(cmflt_pkg::OP_CLEAR_BUS, 0, 0, 0, '0, '0, '0, 0, '0));
      send_request(table_op(cmflt_pkg::OP_LOOKUP, 0, 0, 0, '0, '0, '0, 0, '0));

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS0, 8'd255);
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS1, 8'd0);
            end
            2: begin
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS0, 8'd0);
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS1, 8'd255);
            end
            3: begin
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS0, 8'd9);
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS1, 8'd240);
            end
            4: begin
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS0, cmflt_pkg::CSR_W'($urandom));
               write_min_object(cmflt_pkg::CSR_MIN_OBJECT_BUS1, cmflt_pkg::CSR_W'($urandom));
            end
            default: ;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            quiet = (phase == 2 && i >= 60 && i < 260);
            if ($urandom_range(99) == 0) wait_drained();
            send_request(make_random_item());
         end
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (filter_tables.expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (filter_tables.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/cmflt_pkg.sv
design/cmflt_ram.sv
design/cmflt_engine.sv
design/can_mask_filter_lookup_table_top.sv
design/cmflt_checker.sv
test/can_mask_filter_lookup_table_top_tb.sv
